@@ sv/lpxr_pkg.sv @@
package lpxr_pkg;

  // Field widths of a serial or frame byte and of the emitted byte position
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 6;
  // Frame byte counter; holds the longest frame (header + 255 + checksum)
  localparam int unsigned CNT_W  = 9;
  // Header byte that carries the payload length
  localparam int unsigned LENGTH_INDEX = 3;

  // Controller to datapath
  typedef struct packed {
    logic take;      // a serial byte request is accepted this cycle
    logic rd_start;  // rewind the readout index
    logic rd_en;     // read the store at the readout index
    logic rd_next;   // advance the readout index
  } lpxr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic good_end;  // current byte closes a frame whose checksum and length are good
    logic rd_last;   // readout index is on the final byte of the frame
  } lpxr_sts_t;

endpackage

@@ sv/lpxr_if.sv @@
interface lpxr_in_if import lpxr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpxr_out_if import lpxr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [POS_W-1:0]  byte_position;
  logic              frame_end;

  modport source (output valid, output frame_byte, output byte_position, output frame_end,
                  input ready);
  modport sink   (input valid, input frame_byte, input byte_position, input frame_end,
                  output ready);
endinterface

@@ sv/length_prefixed_xor_frame_receiver_core.sv @@
// Serial bytes are taken one per cycle while a frame is being received.
// On the checksum byte of a good frame readout starts; for each frame byte the store
// is read into the output register (read state), then the byte is shown (show state);
// no serial byte is taken until the last frame byte has been delivered.
// Synchronous active-low reset clears the byte count, running XOR and controller;
// the frame store is not cleared.
module length_prefixed_xor_frame_receiver_core import lpxr_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 4,
  parameter int unsigned MAX_PAYLOAD  = 32
) (
  input logic        clk,
  input logic        rst_n,
  lpxr_in_if.sink    in_if,
  lpxr_out_if.source out_if
);

  lpxr_cmd_t cmd;
  lpxr_sts_t sts;

  lpxr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpxr_dp #(
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_PAYLOAD  (MAX_PAYLOAD)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .rx_byte       (in_if.rx_byte),
    .frame_byte    (out_if.frame_byte),
    .byte_position (out_if.byte_position),
    .frame_end     (out_if.frame_end)
  );

endmodule

@@ sv/lpxr_ctrl.sv @@
module lpxr_ctrl import lpxr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lpxr_sts_t sts,
  output lpxr_cmd_t cmd
);

  localparam logic [1:0] ST_RX   = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       take, give;

  assign in_ready  = (state_r == ST_RX);
  assign out_valid = (state_r == ST_SHOW);
  assign take      = in_valid && in_ready;
  assign give      = out_valid && out_ready;

  // Drive datapath commands
  always_comb begin
    cmd.take     = take;
    cmd.rd_start = take && sts.good_end;
    cmd.rd_en    = (state_r == ST_READ);
    cmd.rd_next  = give && !sts.rd_last;
  end

  // Receive, then read and show each stored byte in turn
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RX: begin
        if (take && sts.good_end) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (give) state_nxt = sts.rd_last ? ST_RX : ST_READ;
      end
      default: state_nxt = ST_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RX;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/lpxr_dp.sv @@
module lpxr_dp import lpxr_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 4,
  parameter int unsigned MAX_PAYLOAD  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lpxr_cmd_t         cmd,
  output lpxr_sts_t         sts,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic [BYTE_W-1:0] frame_byte,
  output logic [POS_W-1:0]  byte_position,
  output logic              frame_end
);

  localparam int unsigned DEPTH = HEADER_BYTES + MAX_PAYLOAD;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [BYTE_W-1:0] store_mem [DEPTH];

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc, total;
  logic [BYTE_W-1:0] par_r, par_nxt;
  logic [BYTE_W-1:0] len_r;
  logic [AW-1:0]     last_idx_r;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [BYTE_W-1:0] rd_data_r;
  logic              at_end;

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign total   = CNT_W'(HEADER_BYTES) + CNT_W'(len_r) + CNT_W'(1);
  assign at_end  = (cnt_inc > CNT_W'(HEADER_BYTES)) && (cnt_inc == total);

  always_comb begin
    sts.good_end = at_end && (rx_byte == par_r) && (len_r <= BYTE_W'(MAX_PAYLOAD));
    sts.rd_last  = (rd_idx_r == last_idx_r);
  end

  // Count the frame and fold bytes into the running XOR; clear on the checksum byte
  always_comb begin
    cnt_nxt = cnt_r;
    par_nxt = par_r;
    if (cmd.take) begin
      if (at_end) begin
        cnt_nxt = '0;
        par_nxt = '0;
      end else begin
        cnt_nxt = cnt_inc;
        par_nxt = par_r ^ rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      par_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      par_r <= par_nxt;
    end
  end

  // Hold the length byte, and the final readout index captured at each frame end
  always_ff @(posedge clk) begin
    if (cmd.take && (cnt_r == CNT_W'(LENGTH_INDEX))) begin
      len_r <= rx_byte;
    end
    if (cmd.take && at_end) begin
      last_idx_r <= AW'(HEADER_BYTES + 32'(len_r) - 1);
    end
  end

  // Write bytes that fit in the store; drop the rest of an oversize frame; read on rd_en
  always_ff @(posedge clk) begin
    if (cmd.take && (cnt_r < CNT_W'(DEPTH))) begin
      store_mem[cnt_r[AW-1:0]] <= rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= store_mem[rd_idx_r];
    end
  end

  // Step the readout index
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.rd_start) begin
      rd_idx_nxt = '0;
    end else if (cmd.rd_next) begin
      rd_idx_nxt = rd_idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
    end
  end

  assign frame_byte    = rd_data_r;
  assign byte_position = POS_W'(rd_idx_r);
  assign frame_end     = sts.rd_last;

endmodule

@@ sv/lpxr_checker.sv @@
module lpxr_checker import lpxr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] frame_byte,
  input logic [POS_W-1:0]  byte_position,
  input logic              frame_end
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte)
      && $stable(byte_position) && $stable(frame_end))
    else $error("stalled result changed");

  // No serial request is taken while a frame is being emitted
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during frame readout");

  // Positions climb by one within a frame
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !frame_end |=> !out_valid ##1
      (out_valid && byte_position == $past(byte_position, 2) + POS_W'(1)))
    else $error("frame byte position skipped");

  // Receiving resumes right after the final frame byte
  a_resume: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && frame_end |=> in_ready && !out_valid)
    else $error("receiver did not resume after frame end");

endmodule

bind length_prefixed_xor_frame_receiver_core lpxr_checker u_lpxr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .frame_byte    (out_if.frame_byte),
  .byte_position (out_if.byte_position),
  .frame_end     (out_if.frame_end)
);

@@ tb/sv/tb_length_prefixed_xor_frame_receiver_core.sv @@
`timescale 1ns / 1ps

module tb_length_prefixed_xor_frame_receiver_core;
  import lpxr_pkg::*;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned MAX_PAYLOAD  = 32;
  localparam int unsigned STORE_DEPTH  = HEADER_BYTES + MAX_PAYLOAD;
  localparam int unsigned STORE_AW     = $clog2(STORE_DEPTH);
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned SHOWN_ERRORS = 10;
  // Marks a frame fill value as "use random bytes"
  localparam logic [8:0]  FILL_RANDOM  = 9'h100;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              is_end;
  } frame_out_t;

  logic clk;
  logic rst_n;

  lpxr_in_if  in_if ();
  lpxr_out_if out_if ();

  length_prefixed_xor_frame_receiver_core #(
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  // Serial bytes waiting to be sent, and released frame bytes still to arrive
  logic [BYTE_W-1:0] rx_pending[$];
  frame_out_t        frame_bytes_due[$];

  // Receiver state as seen by the predictor
  logic [CNT_W-1:0]  frame_count;
  logic [BYTE_W-1:0] frame_xor;
  logic [BYTE_W-1:0] frame_copy[STORE_DEPTH];

  int unsigned total_items;
  int unsigned rx_taken;
  int unsigned error_count;
  int unsigned cycle_count;

  // Clock, reset and known input levels from time zero
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.rx_byte  = '0;
    out_if.ready   = 1'b0;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
      end
    join_none
  end

  // Queue one frame; fill gives the header/payload bytes but the length byte, unless random
  task automatic add_frame(input int unsigned len, input logic [8:0] fill, input bit corrupt);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    sum = '0;
    for (int unsigned k = 0; k < HEADER_BYTES + len; k++) begin
      if (k == LENGTH_INDEX) begin
        b = len[BYTE_W-1:0];
      end else if (fill[8]) begin
        b = BYTE_W'($urandom_range(255));
      end else begin
        b = fill[BYTE_W-1:0];
      end
      sum ^= b;
      rx_pending.push_back(b);
    end
    if (corrupt) begin
      sum ^= BYTE_W'($urandom_range(1, 255));
    end
    rx_pending.push_back(sum);
  endtask

  // Track one accepted serial byte and queue the frame bytes it releases
  task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b);
    int unsigned len;
    int unsigned n;
    frame_out_t  fb;
    if (frame_count < STORE_DEPTH) begin
      frame_copy[frame_count[STORE_AW-1:0]] = b;
    end
    frame_count = frame_count + 1'b1;
    if (frame_count > HEADER_BYTES) begin
      len = 32'(frame_copy[STORE_AW'(LENGTH_INDEX)]);
      if (frame_count == HEADER_BYTES + len + 1) begin
        frame_count = '0;
        // Release only on matching checksum and a length that fit the store
        if (b == frame_xor && len <= MAX_PAYLOAD) begin
          n = HEADER_BYTES + len;
          for (int unsigned k = 0; k < n; k++) begin
            fb.data   = frame_copy[k[STORE_AW-1:0]];
            fb.pos    = k[POS_W-1:0];
            fb.is_end = (k + 1 == n);
            frame_bytes_due.push_back(fb);
          end
        end
        frame_xor = '0;
        return;
      end
    end
    frame_xor ^= b;
  endtask

  // Phase of the run (0 to 3) from the share of serial bytes taken so far
  function automatic int unsigned phase_of_run();
    return (rx_taken * 3) / (total_items == 0 ? 1 : total_items);
  endfunction

  // Build the stimulus
  initial begin
    int unsigned r;
    int unsigned len;
    int unsigned start;
    frame_count = '0;
    frame_xor   = '0;
    rx_taken    = 0;
    error_count = 0;
    total_items = 0;

    // Zero length with all-ones header, zero length with bad checksum,
    // short frames with extreme payload bytes
    add_frame(0, 9'h0FF, 1'b0);
    add_frame(0, 9'h000, 1'b1);
    add_frame(1, 9'h0FF, 1'b0);
    add_frame(2, 9'h000, 1'b0);

    // Random frames: mostly good, some bad checksum, over-length and junk
    start = rx_pending.size();
    add_frame(MAX_PAYLOAD, FILL_RANDOM, 1'b0);
    while (rx_pending.size() - start < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(99);
        if (len < 80) begin
          len = $urandom_range(8);
        end else if (len < 95) begin
          len = $urandom_range(9, MAX_PAYLOAD - 1);
        end else begin
          len = MAX_PAYLOAD;
        end
        add_frame(len, FILL_RANDOM, 1'b0);
      end else if (r < 82) begin
        add_frame($urandom_range(12), FILL_RANDOM, 1'b1);
      end else if (r < 90) begin
        add_frame($urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 16), FILL_RANDOM,
                  ($urandom_range(3) == 0));
      end else begin
        add_frame($urandom_range(40), FILL_RANDOM, ($urandom_range(15) != 0));
      end
    end
    total_items = rx_pending.size();

    // Wait for every byte to go in and every released byte to come out
    while (rx_taken < total_items || frame_bytes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && frame_bytes_due.size() == 0) begin
      $display("tb_length_prefixed_xor_frame_receiver_core: done, clean");
    end else begin
      $display("tb_length_prefixed_xor_frame_receiver_core: done, errors");
    end
    $finish;
  end

  // Serial byte driver: predict on acceptance, then offer the next request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        absorb_rx_byte(in_if.rx_byte);
        rx_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (rx_pending.size() != 0 &&
            $urandom_range(99) >= (phase_of_run() == 0 ? 16 :
                                   phase_of_run() == 1 ? 65 : 0)) begin
          in_if.valid   <= 1'b1;
          in_if.rx_byte <= rx_pending.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Frame byte monitor: stall at random, compare each request with the oldest due
  always @(posedge clk) begin
    frame_out_t got;
    frame_out_t want;
    out_if.ready <= ($urandom_range(99) >= (phase_of_run() == 0 ? 65 :
                                            phase_of_run() == 1 ? 16 : 0));
    if (rst_n && out_if.valid && out_if.ready) begin
      got.data   = out_if.frame_byte;
      got.pos    = out_if.byte_position;
      got.is_end = out_if.frame_end;
      if (frame_bytes_due.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
          $display("unexpected frame byte: data %02h pos %0d end %0b",
                   got.data, got.pos, got.is_end);
        end
      end else begin
        want = frame_bytes_due.pop_front();
        if (got != want) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS) begin
            $display("frame byte mismatch: expected data %02h pos %0d end %0b, got %02h %0d %0b",
                     want.data, want.pos, want.is_end, got.data, got.pos, got.is_end);
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_length_prefixed_xor_frame_receiver_core: done, errors");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

@@ files.f @@
sv/lpxr_pkg.sv
sv/lpxr_if.sv
sv/lpxr_ctrl.sv
sv/lpxr_dp.sv
sv/length_prefixed_xor_frame_receiver_core.sv
sv/lpxr_checker.sv
tb/sv/tb_length_prefixed_xor_frame_receiver_core.sv
